### rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is checked at every rising edge outside reset.
`define CPTE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cpte checker: property violated");

// Property that is checked at every rising edge, during reset too.
`define CPTE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("cpte checker: property violated");

`endif

### rtl/cpte_pkg.sv
// Types, widths and codes of the closest-point-on-triangle-edges block.
// Used by the top level and its checker; depends on nothing.
`default_nettype none

package cpte_pkg;

  // Coordinate width (signed Q12.12) and the widths derived from it.
  localparam int COORD_WIDTH = 24;
  localparam int DW          = COORD_WIDTH + 1;       // edge and offset vectors
  localparam int PW          = 2 * DW;                // one signed product
  localparam int SW          = PW + 2;                // signed dot product
  localparam int LW          = PW;                    // squared edge length
  localparam int RW          = LW + 2;                // divider partial remainder
  localparam int EW          = COORD_WIDTH + 1;       // query minus candidate
  localparam int QW          = 2 * EW;                // one squared term
  localparam int DSW         = 2 * COORD_WIDTH + 4;   // full squared distance
  localparam int DIST_WIDTH  = 2 * COORD_WIDTH + 2;   // reported squared distance

  // Stages from acceptance to the result strobe; the divider has one per bit.
  localparam int LATENCY = 10 + DW;

  // Point slots and edge endpoints.
  localparam int NUM_PTS  = 4;
  localparam int NUM_AX   = 3;
  localparam int NUM_EDGE = 3;
  localparam int PT_QUERY = 3;
  localparam int EDGE_S [NUM_EDGE] = '{0, 0, 1};
  localparam int EDGE_T [NUM_EDGE] = '{1, 2, 2};

  // Edge codes as reported on chosen_edge.
  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_AC = 2'd1;
  localparam logic [1:0] EDGE_BC = 2'd2;

  // How the candidate of one edge is formed.
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_END   = 2'd1;
  localparam logic [1:0] MODE_DIV   = 2'd2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_a_z;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_b_z;
    coord_t vertex_c_x;
    coord_t vertex_c_y;
    coord_t vertex_c_z;
    coord_t query_x;
    coord_t query_y;
    coord_t query_z;
  } cpte_in_t;

  typedef struct packed {
    coord_t                nearest_x;
    coord_t                nearest_y;
    coord_t                nearest_z;
    logic [1:0]            chosen_edge;
    logic [DIST_WIDTH-1:0] distance_squared;
  } cpte_out_t;

endpackage

`default_nettype wire

### rtl/closest_point_on_triangle_edges_unit.sv
// Top level: pipelined closest point on the edges ab, ac and bc of a 3D triangle.
// Depends on cpte_pkg.
`default_nettype none

// A word is accepted at every rising edge with start high; busy never rises, so one
// word per cycle is taken indefinitely. Each result is on result_o for one cycle with
// result_valid_o high, in the order of acceptance; the receiver cannot hold results off.
// The pipeline depth is set by the projection divider, which takes one bit of |d| per
// stage (25 stages for 24-bit coordinates), plus ten stages of input capture, differences,
// products, sums, classification, candidates, offsets, squares, distance sums and selection.
module closest_point_on_triangle_edges_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  input  wire cpte_pkg::cpte_in_t   item_i,
  output logic                      busy,
  output logic                      result_valid_o,
  output cpte_pkg::cpte_out_t       result_o
);

  localparam int CW  = cpte_pkg::COORD_WIDTH;
  localparam int DW  = cpte_pkg::DW;
  localparam int PW  = cpte_pkg::PW;
  localparam int SW  = cpte_pkg::SW;
  localparam int LW  = cpte_pkg::LW;
  localparam int RW  = cpte_pkg::RW;
  localparam int EW  = cpte_pkg::EW;
  localparam int QW  = cpte_pkg::QW;
  localparam int DSW = cpte_pkg::DSW;
  localparam int LAT = cpte_pkg::LATENCY;
  localparam int NP  = cpte_pkg::NUM_PTS;
  localparam int NA  = cpte_pkg::NUM_AX;
  localparam int NE  = cpte_pkg::NUM_EDGE;

  logic accept;
  logic [LAT-1:0] vld_q;

  cpte_pkg::cpte_in_t in_q;
  cpte_pkg::coord_t   pt0 [NP][NA];

  // The pipeline never stalls, so a word is taken whenever start is high.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Valid bits travel alongside the data stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= item_i;
    end
  end

  // Arrange the input word as points by axis.
  always_comb begin
    pt0[0][0] = in_q.vertex_a_x;
    pt0[0][1] = in_q.vertex_a_y;
    pt0[0][2] = in_q.vertex_a_z;
    pt0[1][0] = in_q.vertex_b_x;
    pt0[1][1] = in_q.vertex_b_y;
    pt0[1][2] = in_q.vertex_b_z;
    pt0[2][0] = in_q.vertex_c_x;
    pt0[2][1] = in_q.vertex_c_y;
    pt0[2][2] = in_q.vertex_c_z;
    pt0[3][0] = in_q.query_x;
    pt0[3][1] = in_q.query_y;
    pt0[3][2] = in_q.query_z;
  end

  // Stage 1: edge vectors and offsets of the query from each edge start.
  cpte_pkg::coord_t    pt1_q [NP][NA];
  logic signed [DW-1:0] d1_q [NE][NA];
  logic signed [DW-1:0] w1_q [NE][NA];

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < NP; p++) begin
      for (int k = 0; k < NA; k++) begin
        pt1_q[p][k] <= pt0[p][k];
      end
    end
    for (int e = 0; e < NE; e++) begin
      for (int k = 0; k < NA; k++) begin
        d1_q[e][k] <= DW'(pt0[cpte_pkg::EDGE_T[e]][k]) - DW'(pt0[cpte_pkg::EDGE_S[e]][k]);
        w1_q[e][k] <= DW'(pt0[cpte_pkg::PT_QUERY][k]) - DW'(pt0[cpte_pkg::EDGE_S[e]][k]);
      end
    end
  end

  // Stage 2: per-axis products for the dot products.
  cpte_pkg::coord_t    pt2_q [NP][NA];
  logic signed [DW-1:0] d2_q  [NE][NA];
  logic signed [PW-1:0] dw2_q [NE][NA];
  logic signed [PW-1:0] dd2_q [NE][NA];

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < NP; p++) begin
      for (int k = 0; k < NA; k++) begin
        pt2_q[p][k] <= pt1_q[p][k];
      end
    end
    for (int e = 0; e < NE; e++) begin
      for (int k = 0; k < NA; k++) begin
        d2_q[e][k]  <= d1_q[e][k];
        dw2_q[e][k] <= PW'(d1_q[e][k]) * PW'(w1_q[e][k]);
        dd2_q[e][k] <= PW'(d1_q[e][k]) * PW'(d1_q[e][k]);
      end
    end
  end

  // Stage 3: projection numerator and squared edge length.
  cpte_pkg::coord_t    pt3_q  [NP][NA];
  logic signed [DW-1:0] d3_q   [NE][NA];
  logic signed [SW-1:0] num3_q [NE];
  logic [LW-1:0]        len3_q [NE];

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < NP; p++) begin
      for (int k = 0; k < NA; k++) begin
        pt3_q[p][k] <= pt2_q[p][k];
      end
    end
    for (int e = 0; e < NE; e++) begin
      for (int k = 0; k < NA; k++) begin
        d3_q[e][k] <= d2_q[e][k];
      end
      num3_q[e] <= SW'(dw2_q[e][0]) + SW'(dw2_q[e][1]) + SW'(dw2_q[e][2]);
      len3_q[e] <= LW'($unsigned(dd2_q[e][0])) + LW'($unsigned(dd2_q[e][1]))
                 + LW'($unsigned(dd2_q[e][2]));
    end
  end

  // Divider chain storage; slot 0 is the classification stage.
  cpte_pkg::coord_t dv_pt_q   [DW+1][NP][NA];
  logic [1:0]       dv_mode_q [DW+1][NE];
  logic [DW-1:0]    dv_dmag_q [DW+1][NE][NA];
  logic             dv_dneg_q [DW+1][NE][NA];
  logic [LW-1:0]    dv_num_q  [DW+1][NE];
  logic [LW-1:0]    dv_len_q  [DW+1][NE];
  logic [RW-1:0]    dv_rem_q  [DW+1][NE][NA];
  logic [DW-1:0]    dv_quo_q  [DW+1][NE][NA];

  // Stage 4: decide start, end or interior point and set up the division.
  always_ff @(posedge clk_i) begin
    for (int p = 0; p < NP; p++) begin
      for (int k = 0; k < NA; k++) begin
        dv_pt_q[0][p][k] <= pt3_q[p][k];
      end
    end
    for (int e = 0; e < NE; e++) begin
      if ((len3_q[e] == '0) || (num3_q[e] <= 0)) begin
        dv_mode_q[0][e] <= cpte_pkg::MODE_START;
      end else if (num3_q[e] >= $signed({2'b00, len3_q[e]})) begin
        dv_mode_q[0][e] <= cpte_pkg::MODE_END;
      end else begin
        dv_mode_q[0][e] <= cpte_pkg::MODE_DIV;
      end
      dv_num_q[0][e] <= num3_q[e][LW-1:0];
      dv_len_q[0][e] <= len3_q[e];
      for (int k = 0; k < NA; k++) begin
        dv_dneg_q[0][e][k] <= d3_q[e][k][DW-1];
        dv_dmag_q[0][e][k] <= d3_q[e][k][DW-1] ? $unsigned(-d3_q[e][k])
                                               : $unsigned(d3_q[e][k]);
        dv_rem_q[0][e][k]  <= '0;
        dv_quo_q[0][e][k]  <= '0;
      end
    end
  end

  // Divider: quotient of |d| * num / len, one bit of |d| per stage. With the
  // remainder below len and num below len, each step yields a digit of 0 to 2.
  for (genvar g = 0; g < DW; g++) begin : g_div
    logic [RW-1:0] part  [NE][NA];
    logic [RW-1:0] rem_n [NE][NA];
    logic [DW-1:0] quo_n [NE][NA];

    always_comb begin
      for (int e = 0; e < NE; e++) begin
        for (int k = 0; k < NA; k++) begin
          part[e][k] = {dv_rem_q[g][e][k][RW-2:0], 1'b0}
                     + (dv_dmag_q[g][e][k][DW-1-g] ? {2'b00, dv_num_q[g][e]} : '0);
          if (part[e][k] >= {1'b0, dv_len_q[g][e], 1'b0}) begin
            rem_n[e][k] = part[e][k] - {1'b0, dv_len_q[g][e], 1'b0};
            quo_n[e][k] = {dv_quo_q[g][e][k][DW-2:0], 1'b0} + DW'(2);
          end else if (part[e][k] >= {2'b00, dv_len_q[g][e]}) begin
            rem_n[e][k] = part[e][k] - {2'b00, dv_len_q[g][e]};
            quo_n[e][k] = {dv_quo_q[g][e][k][DW-2:0], 1'b1};
          end else begin
            rem_n[e][k] = part[e][k];
            quo_n[e][k] = {dv_quo_q[g][e][k][DW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      for (int p = 0; p < NP; p++) begin
        for (int k = 0; k < NA; k++) begin
          dv_pt_q[g+1][p][k] <= dv_pt_q[g][p][k];
        end
      end
      for (int e = 0; e < NE; e++) begin
        dv_mode_q[g+1][e] <= dv_mode_q[g][e];
        dv_num_q[g+1][e]  <= dv_num_q[g][e];
        dv_len_q[g+1][e]  <= dv_len_q[g][e];
        for (int k = 0; k < NA; k++) begin
          dv_dmag_q[g+1][e][k] <= dv_dmag_q[g][e][k];
          dv_dneg_q[g+1][e][k] <= dv_dneg_q[g][e][k];
          dv_rem_q[g+1][e][k]  <= rem_n[e][k];
          dv_quo_q[g+1][e][k]  <= quo_n[e][k];
        end
      end
    end
  end

  // Candidate point of each edge.
  cpte_pkg::coord_t    cand   [NE][NA];
  logic signed [DW:0]   cand_w [NE][NA];
  cpte_pkg::coord_t    r_q    [NE][NA];
  cpte_pkg::coord_t    pr_q   [NA];

  always_comb begin
    for (int e = 0; e < NE; e++) begin
      for (int k = 0; k < NA; k++) begin
        cand_w[e][k] = dv_dneg_q[DW][e][k]
          ? (DW+1)'(dv_pt_q[DW][cpte_pkg::EDGE_S[e]][k]) - $signed({1'b0, dv_quo_q[DW][e][k]})
          : (DW+1)'(dv_pt_q[DW][cpte_pkg::EDGE_S[e]][k]) + $signed({1'b0, dv_quo_q[DW][e][k]});
        case (dv_mode_q[DW][e])
          cpte_pkg::MODE_START: cand[e][k] = dv_pt_q[DW][cpte_pkg::EDGE_S[e]][k];
          cpte_pkg::MODE_END:   cand[e][k] = dv_pt_q[DW][cpte_pkg::EDGE_T[e]][k];
          default:              cand[e][k] = cand_w[e][k][CW-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NA; k++) begin
      pr_q[k] <= dv_pt_q[DW][cpte_pkg::PT_QUERY][k];
    end
    for (int e = 0; e < NE; e++) begin
      for (int k = 0; k < NA; k++) begin
        r_q[e][k] <= cand[e][k];
      end
    end
  end

  // Offsets from the candidates to the query, then their squares.
  logic signed [EW-1:0] e_q  [NE][NA];
  cpte_pkg::coord_t     re_q [NE][NA];
  logic [QW-1:0]        sq_q [NE][NA];
  cpte_pkg::coord_t     rs_q [NE][NA];

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < NE; e++) begin
      for (int k = 0; k < NA; k++) begin
        e_q[e][k]  <= EW'(pr_q[k]) - EW'(r_q[e][k]);
        re_q[e][k] <= r_q[e][k];
        sq_q[e][k] <= $unsigned(QW'(e_q[e][k]) * QW'(e_q[e][k]));
        rs_q[e][k] <= re_q[e][k];
      end
    end
  end

  // Squared distance of each candidate.
  logic [DSW-1:0]   dsum_q [NE];
  cpte_pkg::coord_t rd_q   [NE][NA];

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < NE; e++) begin
      dsum_q[e] <= DSW'(sq_q[e][0]) + DSW'(sq_q[e][1]) + DSW'(sq_q[e][2]);
      for (int k = 0; k < NA; k++) begin
        rd_q[e][k] <= rs_q[e][k];
      end
    end
  end

  // Pick the nearest: ab only if strictly closer than ac, then the pair
  // winner only if strictly closer than bc.
  logic [1:0]          win;
  cpte_pkg::cpte_out_t out_d;
  cpte_pkg::cpte_out_t out_q;

  always_comb begin
    if (dsum_q[0] < dsum_q[1]) begin
      win = (dsum_q[0] < dsum_q[2]) ? cpte_pkg::EDGE_AB : cpte_pkg::EDGE_BC;
    end else begin
      win = (dsum_q[1] < dsum_q[2]) ? cpte_pkg::EDGE_AC : cpte_pkg::EDGE_BC;
    end
    out_d.nearest_x        = rd_q[win][0];
    out_d.nearest_y        = rd_q[win][1];
    out_d.nearest_z        = rd_q[win][2];
    out_d.chosen_edge      = win;
    out_d.distance_squared = dsum_q[win][cpte_pkg::DIST_WIDTH-1:0];
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_valid_o = vld_q[LAT-1];
  assign result_o       = out_q;

endmodule

`default_nettype wire

### rtl/cpte_checker.sv
// Port-level checker for the closest-point-on-triangle-edges block, with its bind.
// Depends on cpte_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module cpte_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start,
  input wire cpte_pkg::cpte_in_t  item_i,
  input wire logic                busy,
  input wire logic                result_valid_o,
  input wire cpte_pkg::cpte_out_t result_o
);

  localparam int LAT = cpte_pkg::LATENCY;

  logic edge_ok;
  logic zero_dist;

  // The reported edge code is one of the edge codes ab, ac and bc.
  assign edge_ok = (result_o.chosen_edge == cpte_pkg::EDGE_AB)
                || (result_o.chosen_edge == cpte_pkg::EDGE_AC)
                || (result_o.chosen_edge == cpte_pkg::EDGE_BC);

  // A valid result with a zero squared distance.
  assign zero_dist = result_valid_o && (result_o.distance_squared == '0);

  // The block never holds words off.
  `CPTE_ASSERT(a_never_busy, clk_i, rst_ni, !busy)

  // Every result strobe traces back to an accepted word.
  `CPTE_ASSERT(a_latency, clk_i, rst_ni, result_valid_o |-> $past(start && !busy, LAT))

  // The chosen edge is ab, ac or bc.
  `CPTE_ASSERT(a_edge_code, clk_i, rst_ni, result_valid_o |-> edge_ok)

  // A zero distance means the reported x coordinate is that of the query point.
  `CPTE_ASSERT(a_zero_dist, clk_i, rst_ni, zero_dist |-> (result_o.nearest_x == $past(item_i.query_x, LAT)))

  // No result strobe while reset is applied.
  `CPTE_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !result_valid_o)

endmodule

bind closest_point_on_triangle_edges_unit cpte_checker u_cpte_checker (.*);

`default_nettype wire

### dv/tb_closest_point_on_triangle_edges_unit.sv
// Testbench for closest_point_on_triangle_edges_unit: directed table plus random words,
// each result checked field by field against an in-bench predictor. Depends on cpte_pkg.
`timescale 1ns / 100ps

module tb_closest_point_on_triangle_edges_unit;

  localparam int NUM_RANDOM = 1030;
  localparam int IDLE_LIMIT = 2000;
  localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [23:0] CMIN = -24'sh800000;

  // One row of the directed table; has_exp marks rows with typed-in results.
  typedef struct {
    cpte_pkg::cpte_in_t  word;
    bit                  has_exp;
    cpte_pkg::cpte_out_t exp;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  cpte_pkg::cpte_in_t  item_i;
  logic                busy;
  logic                result_valid_o;
  cpte_pkg::cpte_out_t result_o;

  cpte_pkg::cpte_out_t nearest_queue[$];
  int                  error_count;
  int                  idle_cycles;

  closest_point_on_triangle_edges_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .item_i(item_i),
    .busy(busy), .result_valid_o(result_valid_o), .result_o(result_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Projects p onto segment s-t with the parameter clamped to [0,1].
  function automatic void project_on_edge(input longint s[3], input longint t[3],
                                          input longint p[3], output longint r[3],
                                          output logic [127:0] dist_sq);
    logic signed [127:0] num, len, e;
    longint d[3];
    num = 0;
    len = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = t[i] - s[i];
      num += 128'(d[i]) * 128'(p[i] - s[i]);
      len += 128'(d[i]) * 128'(d[i]);
    end
    for (int i = 0; i < 3; i++) begin
      if (len == 0 || num <= 0) r[i] = s[i];
      else if (num >= len) r[i] = t[i];
      else r[i] = s[i] + longint'((128'(d[i]) * num) / len); // truncates toward s
    end
    dist_sq = 0;
    for (int i = 0; i < 3; i++) begin
      e = 128'(p[i] - r[i]);
      dist_sq += e * e;
    end
  endfunction

  // Nearest point over the edges ab, ac and bc, with strict tie rules ab, ac, then bc.
  function automatic cpte_pkg::cpte_out_t nearest_edge_point(input cpte_pkg::cpte_in_t w);
    longint a[3], b[3], c[3], p[3], rab[3], rac[3], rbc[3], win[3];
    logic [127:0] dab, dac, dbc, dw;
    cpte_pkg::cpte_out_t o;
    a = '{w.vertex_a_x, w.vertex_a_y, w.vertex_a_z};
    b = '{w.vertex_b_x, w.vertex_b_y, w.vertex_b_z};
    c = '{w.vertex_c_x, w.vertex_c_y, w.vertex_c_z};
    p = '{w.query_x, w.query_y, w.query_z};
    project_on_edge(a, b, p, rab, dab);
    project_on_edge(a, c, p, rac, dac);
    project_on_edge(b, c, p, rbc, dbc);
    if (dab < dac && dab < dbc) begin
      win = rab; dw = dab; o.chosen_edge = cpte_pkg::EDGE_AB;
    end else if (!(dab < dac) && dac < dbc) begin
      win = rac; dw = dac; o.chosen_edge = cpte_pkg::EDGE_AC;
    end else begin
      win = rbc; dw = dbc; o.chosen_edge = cpte_pkg::EDGE_BC;
    end
    o.nearest_x = cpte_pkg::coord_t'(win[0]);
    o.nearest_y = cpte_pkg::coord_t'(win[1]);
    o.nearest_z = cpte_pkg::coord_t'(win[2]);
    o.distance_squared = dw[cpte_pkg::DIST_WIDTH-1:0];
    return o;
  endfunction

  function automatic cpte_pkg::coord_t rand_coord(input int mode);
    case (mode)
      0: return cpte_pkg::coord_t'($urandom);
      1: return cpte_pkg::coord_t'($urandom_range(0, 16'hFFFF)) - 24'sh8000;
      default: return ($urandom_range(0, 1) != 0) ? CMAX : CMIN;
    endcase
  endfunction

  function automatic cpte_pkg::cpte_in_t rand_word();
    cpte_pkg::cpte_in_t w;
    cpte_pkg::coord_t   v[12];
    int                 mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++)
      v[i] = rand_coord(mode < 5 ? 0 : (mode < 9 ? 1 : $urandom_range(0, 2)));
    // Sometimes collapse an edge or put the query on a vertex.
    case ($urandom_range(0, 7))
      0: v[3:5] = v[0:2];
      1: v[6:8] = v[3:5];
      2: v[9:11] = v[0:2];
      3: begin v[3:5] = v[0:2]; v[6:8] = v[0:2]; end
      default: ;
    endcase
    w = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
    return w;
  endfunction

  // Drives one word and holds it until the block accepts it.
  task automatic send_word(input cpte_pkg::cpte_in_t w, input bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    nearest_queue.push_back(nearest_edge_point(w));
    @(negedge clk_i);
  endtask

  // Result checking at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      cpte_pkg::cpte_out_t e;
      if (nearest_queue.size() == 0) begin
        $error("result with no word outstanding");
        error_count++;
      end else begin
        e = nearest_queue.pop_front();
        if (result_o.nearest_x !== e.nearest_x) begin
          $error("nearest_x: expected %0d, got %0d", e.nearest_x, result_o.nearest_x);
          error_count++;
        end
        if (result_o.nearest_y !== e.nearest_y) begin
          $error("nearest_y: expected %0d, got %0d", e.nearest_y, result_o.nearest_y);
          error_count++;
        end
        if (result_o.nearest_z !== e.nearest_z) begin
          $error("nearest_z: expected %0d, got %0d", e.nearest_z, result_o.nearest_z);
          error_count++;
        end
        if (result_o.chosen_edge !== e.chosen_edge) begin
          $error("chosen_edge: expected %0d, got %0d", e.chosen_edge,
                 result_o.chosen_edge);
          error_count++;
        end
        if (result_o.distance_squared !== e.distance_squared) begin
          $error("distance_squared: expected %0d, got %0d", e.distance_squared,
                 result_o.distance_squared);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which nothing is accepted and no result comes out.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("closest_point_on_triangle_edges_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t table_rows[$];
    dir_row_t row;
    cpte_pkg::cpte_in_t w;
    error_count   = 0;
    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // All zero: degenerate triangle, ties go to bc.
    row.word = '0; row.has_exp = 1;
    row.exp = '{nearest_x: 0, nearest_y: 0, nearest_z: 0,
                chosen_edge: cpte_pkg::EDGE_BC, distance_squared: 0};
    table_rows.push_back(row);
    // Collapsed triangle at the positive corner, query at the negative corner.
    row.word = {{9{CMAX}}, {3{CMIN}}};
    row.exp = '{nearest_x: CMAX, nearest_y: CMAX, nearest_z: CMAX,
                chosen_edge: cpte_pkg::EDGE_BC,
                distance_squared: 3 * ((50'd1 << 24) - 1) ** 2};
    table_rows.push_back(row);
    // Collapsed triangle at the negative corner, query at the positive corner.
    row.word = {{9{CMIN}}, {3{CMAX}}};
    row.exp = '{nearest_x: CMIN, nearest_y: CMIN, nearest_z: CMIN,
                chosen_edge: cpte_pkg::EDGE_BC,
                distance_squared: 3 * ((50'd1 << 24) - 1) ** 2};
    table_rows.push_back(row);
    row.has_exp = 0;
    // Full-range edges with the query beyond each end, at middles and on vertices.
    row.word = {CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, 24'sd0, {3{24'sd0}}};
    table_rows.push_back(row);
    row.word = {CMIN, 24'sd0, 24'sd0, CMAX, 24'sd0, 24'sd0, 24'sd0, CMAX, 24'sd0,
                CMAX, CMIN, CMAX};
    table_rows.push_back(row);
    row.word = {24'sd0, 24'sd0, 24'sd0, 24'sd4096, 24'sd0, 24'sd0, 24'sd0, 24'sd4096,
                24'sd0, -24'sd100, 24'sd5, 24'sd7};
    table_rows.push_back(row);
    row.word = {24'sd0, 24'sd0, 24'sd0, 24'sd4096, 24'sd0, 24'sd0, 24'sd0, 24'sd4096,
                24'sd0, 24'sd9000, -24'sd3, 24'sd1};
    table_rows.push_back(row);
    row.word = {24'sd0, 24'sd0, 24'sd0, 24'sd3, 24'sd0, 24'sd0, 24'sd0, 24'sd7, 24'sd0,
                24'sd1, -24'sd5, 24'sd0};
    table_rows.push_back(row);
    row.word = {24'sd10, 24'sd10, 24'sd10, 24'sd10, 24'sd10, 24'sd10, CMAX, CMIN, CMAX,
                24'sd10, 24'sd10, 24'sd10};
    table_rows.push_back(row);
    row.word = {-24'sd7, 24'sd3, 24'sd0, 24'sd7, 24'sd3, 24'sd0, 24'sd0, -24'sd9, 24'sd0,
                24'sd0, 24'sd0, 24'sd0};
    table_rows.push_back(row);
    row.word = {CMAX, CMIN, 24'sd0, CMIN, CMAX, 24'sd0, CMAX, CMAX, CMIN,
                24'sd1, -24'sd1, 24'sd1};
    table_rows.push_back(row);
    row.word = {24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
                CMAX, 24'sd0, CMIN};
    table_rows.push_back(row);

    foreach (table_rows[i]) begin
      if (table_rows[i].has_exp &&
          nearest_edge_point(table_rows[i].word) !== table_rows[i].exp) begin
        $error("directed row %0d: predictor disagrees with typed-in result", i);
        error_count++;
      end
      send_word(table_rows[i].word, 0);
    end

    // Random words; idling only in the first part.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      w = rand_word();
      send_word(w, n < NUM_RANDOM * 3 / 4);
    end
    start <= 1'b0;

    // Drain, then allow the pipeline latency once more.
    while (nearest_queue.size() != 0) @(negedge clk_i);
    repeat (cpte_pkg::LATENCY + 5) @(negedge clk_i);
    if (error_count == 0)
      $display("closest_point_on_triangle_edges_unit test passed");
    else
      $display("closest_point_on_triangle_edges_unit test failed");
    $finish;
  end

endmodule
